// ===== rtl/core/yuvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuvc_pkg
// Shared types, constants and arithmetic helpers for the YUV 4:2:0 to BGRA
// pixel-pair converter.
// ----------------------------------------------------------------------------
package yuvc_pkg;

    localparam int SampleW = 16;
    localparam int PixelW  = 8;
    localparam int DiffW   = 11;   // signed sample minus offset
    localparam int LumaW   = 20;   // signed luma product
    localparam int ChromaW = 20;   // signed chroma operand after stage 1
    localparam int TermW   = 21;   // signed chroma contribution per channel
    localparam int SumW    = 22;   // signed channel sum before the shift
    localparam int ProdW   = 32;   // signed wide chroma product

    // Limited-range offsets for both sample formats
    localparam logic signed [DiffW-1:0] LumaOff8    = 11'sd16;
    localparam logic signed [DiffW-1:0] ChromaOff8  = 11'sd128;
    localparam logic signed [DiffW-1:0] LumaOff10   = 11'sd64;
    localparam logic signed [DiffW-1:0] ChromaOff10 = 11'sd512;

    localparam logic signed [LumaW-1:0]   LumaGain   = 20'sd298;
    localparam logic signed [ChromaW-1:0] ChromaGain = 20'sd291;

    // BT.601 8-bit coefficients
    localparam logic signed [TermW-1:0] Cr601R  = 21'sd409;
    localparam logic signed [TermW-1:0] Cb601G  = 21'sd100;
    localparam logic signed [TermW-1:0] Cr601G  = 21'sd208;
    localparam logic signed [TermW-1:0] Cb601B  = 21'sd516;
    localparam logic signed [TermW-1:0] Round8  = 21'sd128;

    // BT.709 10-bit coefficients
    localparam logic signed [ProdW-1:0] Cr709R  = 32'sd1613;
    localparam logic signed [ProdW-1:0] Cb709G  = 32'sd192;
    localparam logic signed [ProdW-1:0] Cr709G  = 32'sd480;
    localparam logic signed [ProdW-1:0] Cb709B  = 32'sd1900;

    typedef enum logic {
        FMT_NV12 = 1'b0,
        FMT_P010 = 1'b1
    } yuvc_format_t;

    // Pipeline control handed from the top level to the chroma path and the lanes
    typedef struct packed {
        yuvc_format_t fmt;
        logic         adv_s1;
        logic         adv_s2;
        logic         adv_s3;
    } yuvc_ctrl_t;

    // Sample minus its limited-range offset
    function automatic logic signed [DiffW-1:0] sample_diff(
        input logic [SampleW-1:0] s,
        input yuvc_format_t       fmt,
        input logic               is_luma
    );
        logic signed [DiffW-1:0] code;
        logic signed [DiffW-1:0] off;
        begin
            if (fmt == FMT_P010)
            begin
                code = $signed({1'b0, s[15:6]});
                off  = is_luma ? LumaOff10 : ChromaOff10;
            end
            else
            begin
                code = $signed({3'b000, s[7:0]});
                off  = is_luma ? LumaOff8 : ChromaOff8;
            end
            return code - off;
        end
    endfunction

    // Divide by 1024 truncating toward zero
    function automatic logic signed [TermW-1:0] div1024_trunc(
        input logic signed [ProdW-1:0] x
    );
        logic signed [ProdW-1:0] biased;
        begin
            biased = x + (x[ProdW-1] ? 32'sd1023 : 32'sd0);
            return biased[TermW+9:10];
        end
    endfunction

    function automatic logic [PixelW-1:0] clamp8(input logic signed [SumW-1:0] x);
        begin
            if (x < 0)
                return 8'd0;
            else if (x > 22'sd255)
                return 8'd255;
            else
                return x[PixelW-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/yuv420_to_bgra_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuv420_to_bgra_converter
// Converts a luma pair and its shared chroma pair into two clamped BGR pixels,
// NV12/BT.601 or P010/BT.709 as selected by the format register.
//
//   channel   handshake                 payload
//   pair      pair_valid / pair_stall   luma_first, luma_second,
//                                       chroma_blue, chroma_red
//   pixel     pixel_valid / pixel_stall blue/green/red _first, _second
//   format    format_valid/format_ready format_data
//
// Three register stages: operand scaling, chroma products, sum and clamp in
// the output register. One pair per clock while the output is not stalled.
// Stall reaches every stage combinationally; bubbles are squeezed out.
// Reset clears the stage valids and sets the format to NV12.
// ----------------------------------------------------------------------------
module yuv420_to_bgra_converter (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         pair_valid,
    output logic        pair_stall,
    input  wire  [15:0] luma_first,
    input  wire  [15:0] luma_second,
    input  wire  [15:0] chroma_blue,
    input  wire  [15:0] chroma_red,
    output logic        pixel_valid,
    input  wire         pixel_stall,
    output logic [7:0]  blue_first,
    output logic [7:0]  green_first,
    output logic [7:0]  red_first,
    output logic [7:0]  blue_second,
    output logic [7:0]  green_second,
    output logic [7:0]  red_second,
    input  wire         format_valid,
    output logic        format_ready,
    input  wire         format_data
);

    yuvc_pkg::yuvc_format_t fmt_next, fmt_reg;
    logic v1_next, v1_reg;
    logic v2_next, v2_reg;
    logic v3_next, v3_reg;
    logic ready1, ready2, ready3;
    yuvc_pkg::yuvc_ctrl_t ctrl;

    logic signed [yuvc_pkg::TermW-1:0] term_r, term_g, term_b;

    assign format_ready = 1'b1;

    // a stage loads when it is empty or the stage after it moves
    assign ready3 = !v3_reg || !pixel_stall;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    always_comb
    begin
        fmt_next = fmt_reg;
        if (format_valid)
            fmt_next = format_data ? yuvc_pkg::FMT_P010 : yuvc_pkg::FMT_NV12;
        v1_next = ready1 ? pair_valid : v1_reg;
        v2_next = ready2 ? v1_reg : v2_reg;
        v3_next = ready3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= yuvc_pkg::FMT_NV12;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            fmt_reg <= fmt_next;
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            v3_reg  <= v3_next;
        end
    end

    always_comb
    begin
        ctrl.fmt    = fmt_reg;
        ctrl.adv_s1 = ready1;
        ctrl.adv_s2 = ready2;
        ctrl.adv_s3 = ready3;
    end

    assign pair_stall  = !ready1;
    assign pixel_valid = v3_reg;

    yuvc_chroma u_chroma (
        .clk         (clk),
        .ctrl        (ctrl),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .term_r      (term_r),
        .term_g      (term_g),
        .term_b      (term_b)
    );

    yuvc_lane u_lane_first (
        .clk    (clk),
        .ctrl   (ctrl),
        .luma   (luma_first),
        .term_r (term_r),
        .term_g (term_g),
        .term_b (term_b),
        .blue   (blue_first),
        .green  (green_first),
        .red    (red_first)
    );

    yuvc_lane u_lane_second (
        .clk    (clk),
        .ctrl   (ctrl),
        .luma   (luma_second),
        .term_r (term_r),
        .term_g (term_g),
        .term_b (term_b),
        .blue   (blue_second),
        .green  (green_second),
        .red    (red_second)
    );

`ifndef SYNTHESIS
    // a full pipeline with a blocked output must push back on the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && pixel_stall) |-> pair_stall)
        else $error("full pipeline did not stall the input");

    // an accepted pair lands in stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        (pair_valid && !pair_stall) |=> v1_reg)
        else $error("accepted pair lost at stage 1");

    // a stage-2 beat moves into the output register when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && ready3) |=> pixel_valid)
        else $error("stage 2 beat dropped");

    // an output beat held under stall keeps its pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && pixel_stall) |=> ($stable(blue_first) && $stable(red_second)))
        else $error("stalled output changed");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/yuvc_chroma.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuvc_chroma
// Shared chroma path: offsets the U/V pair and scales it in P010 mode, then forms the
// per-channel chroma contribution that both luma lanes add.
// ----------------------------------------------------------------------------
module yuvc_chroma (
    input  wire                                          clk,
    input  wire yuvc_pkg::yuvc_ctrl_t                    ctrl,
    input  wire [yuvc_pkg::SampleW-1:0]                  chroma_blue,
    input  wire [yuvc_pkg::SampleW-1:0]                  chroma_red,
    output logic signed [yuvc_pkg::TermW-1:0]            term_r,
    output logic signed [yuvc_pkg::TermW-1:0]            term_g,
    output logic signed [yuvc_pkg::TermW-1:0]            term_b
);

    logic signed [yuvc_pkg::DiffW-1:0]   d_diff;
    logic signed [yuvc_pkg::DiffW-1:0]   e_diff;
    logic signed [yuvc_pkg::ChromaW-1:0] du_next, du_reg;
    logic signed [yuvc_pkg::ChromaW-1:0] dv_next, dv_reg;
    logic signed [yuvc_pkg::ProdW-1:0]   p_rv, p_gu, p_gv, p_bu;
    logic signed [yuvc_pkg::TermW-1:0]   d_ext, e_ext;
    logic signed [yuvc_pkg::TermW-1:0]   r_next, r_reg;
    logic signed [yuvc_pkg::TermW-1:0]   g_next, g_reg;
    logic signed [yuvc_pkg::TermW-1:0]   b_next, b_reg;

    // Stage 1: offset, then scale by 291 in P010 mode; NV12 keeps the raw diff
    always_comb
    begin
        d_diff = yuvc_pkg::sample_diff(chroma_blue, ctrl.fmt, 1'b0);
        e_diff = yuvc_pkg::sample_diff(chroma_red,  ctrl.fmt, 1'b0);
        if (ctrl.fmt == yuvc_pkg::FMT_P010)
        begin
            du_next = yuvc_pkg::ChromaW'(d_diff) * yuvc_pkg::ChromaGain;
            dv_next = yuvc_pkg::ChromaW'(e_diff) * yuvc_pkg::ChromaGain;
        end
        else
        begin
            du_next = yuvc_pkg::ChromaW'(d_diff);
            dv_next = yuvc_pkg::ChromaW'(e_diff);
        end
    end

    // Stage 2: coefficient products
    always_comb
    begin
        p_rv  = yuvc_pkg::ProdW'(dv_reg) * yuvc_pkg::Cr709R;
        p_gu  = yuvc_pkg::ProdW'(du_reg) * yuvc_pkg::Cb709G;
        p_gv  = yuvc_pkg::ProdW'(dv_reg) * yuvc_pkg::Cr709G;
        p_bu  = yuvc_pkg::ProdW'(du_reg) * yuvc_pkg::Cb709B;
        d_ext = yuvc_pkg::TermW'(du_reg);
        e_ext = yuvc_pkg::TermW'(dv_reg);
        if (ctrl.fmt == yuvc_pkg::FMT_P010)
        begin
            r_next = yuvc_pkg::div1024_trunc(p_rv);
            g_next = -yuvc_pkg::div1024_trunc(p_gu) - yuvc_pkg::div1024_trunc(p_gv);
            b_next = yuvc_pkg::div1024_trunc(p_bu);
        end
        else
        begin
            // fold the rounding offset into the chroma term
            r_next = e_ext * yuvc_pkg::Cr601R + yuvc_pkg::Round8;
            g_next = yuvc_pkg::Round8 - d_ext * yuvc_pkg::Cb601G
                     - e_ext * yuvc_pkg::Cr601G;
            b_next = d_ext * yuvc_pkg::Cb601B + yuvc_pkg::Round8;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_s1)
        begin
            du_reg <= du_next;
            dv_reg <= dv_next;
        end
        if (ctrl.adv_s2)
        begin
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
    end

    assign term_r = r_reg;
    assign term_g = g_reg;
    assign term_b = b_reg;

endmodule
`default_nettype wire

// ===== rtl/core/yuvc_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yuvc_lane
// One luma lane: scales its luma sample, adds the shared chroma terms,
// shifts and clamps to three 8-bit channels.
// ----------------------------------------------------------------------------
module yuvc_lane (
    input  wire                                clk,
    input  wire yuvc_pkg::yuvc_ctrl_t          ctrl,
    input  wire [yuvc_pkg::SampleW-1:0]        luma,
    input  wire signed [yuvc_pkg::TermW-1:0]   term_r,
    input  wire signed [yuvc_pkg::TermW-1:0]   term_g,
    input  wire signed [yuvc_pkg::TermW-1:0]   term_b,
    output logic [yuvc_pkg::PixelW-1:0]        blue,
    output logic [yuvc_pkg::PixelW-1:0]        green,
    output logic [yuvc_pkg::PixelW-1:0]        red
);

    logic signed [yuvc_pkg::LumaW-1:0] cy_next, cy_reg, cy_d_reg;
    logic signed [yuvc_pkg::SumW-1:0]  sum_r, sum_g, sum_b;
    logic signed [yuvc_pkg::SumW-1:0]  sh_r, sh_g, sh_b;
    logic [yuvc_pkg::PixelW-1:0]       b_next, b_reg;
    logic [yuvc_pkg::PixelW-1:0]       g_next, g_reg;
    logic [yuvc_pkg::PixelW-1:0]       r_next, r_reg;

    assign cy_next = yuvc_pkg::LumaW'(yuvc_pkg::sample_diff(luma, ctrl.fmt, 1'b1))
                     * yuvc_pkg::LumaGain;

    always_comb
    begin
        sum_r = yuvc_pkg::SumW'(cy_d_reg) + yuvc_pkg::SumW'(term_r);
        sum_g = yuvc_pkg::SumW'(cy_d_reg) + yuvc_pkg::SumW'(term_g);
        sum_b = yuvc_pkg::SumW'(cy_d_reg) + yuvc_pkg::SumW'(term_b);
        if (ctrl.fmt == yuvc_pkg::FMT_P010)
        begin
            sh_r = sum_r >>> 10;
            sh_g = sum_g >>> 10;
            sh_b = sum_b >>> 10;
        end
        else
        begin
            sh_r = sum_r >>> 8;
            sh_g = sum_g >>> 8;
            sh_b = sum_b >>> 8;
        end
        r_next = yuvc_pkg::clamp8(sh_r);
        g_next = yuvc_pkg::clamp8(sh_g);
        b_next = yuvc_pkg::clamp8(sh_b);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_s1)
            cy_reg <= cy_next;
        // hold luma alongside the chroma products
        if (ctrl.adv_s2)
            cy_d_reg <= cy_reg;
        if (ctrl.adv_s3)
        begin
            b_reg <= b_next;
            g_reg <= g_next;
            r_reg <= r_next;
        end
    end

    assign blue  = b_reg;
    assign green = g_reg;
    assign red   = r_reg;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - pixel-pair YCbCr to BGR converter testbench
// Streams luma/chroma pairs through the converter in both sample formats and
// checks every output beat against a local fixed-point color matrix model.
// Covers directed corner codes, random mixed traffic with idle bursts on both
// sides, a long output hold-off that backs up the pipeline, and a gap-free run.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MaxQuietCycles = 2000;   // no beat for this long ends the run
    localparam int SettleCycles   = 10;     // pipeline is three stages deep

    typedef struct packed {
        logic [15:0] luma_first;
        logic [15:0] luma_second;
        logic [15:0] chroma_blue;
        logic [15:0] chroma_red;
    } ycbcr_pair_t;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } bgr_t;

    typedef struct packed {
        bgr_t first;
        bgr_t second;
    } bgr_pair_t;

    logic        clk;
    logic        rst_n;
    logic        pair_valid;
    logic        pair_stall;
    logic [15:0] luma_first;
    logic [15:0] luma_second;
    logic [15:0] chroma_blue;
    logic [15:0] chroma_red;
    logic        pixel_valid;
    logic        pixel_stall;
    logic [7:0]  blue_first;
    logic [7:0]  green_first;
    logic [7:0]  red_first;
    logic [7:0]  blue_second;
    logic [7:0]  green_second;
    logic [7:0]  red_second;
    logic        format_valid;
    logic        format_ready;
    logic        format_data;

    yuvc_pkg::yuvc_format_t format_model;
    bgr_pair_t    expected_pixels[$];
    int           mismatch_count;
    int           quiet_cycles;
    bit           tx_gaps_on;
    bit           rx_gaps_on;
    int           hold_request;

    yuv420_to_bgra_converter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .luma_first   (luma_first),
        .luma_second  (luma_second),
        .chroma_blue  (chroma_blue),
        .chroma_red   (chroma_red),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .blue_first   (blue_first),
        .green_first  (green_first),
        .red_first    (red_first),
        .blue_second  (blue_second),
        .green_second (green_second),
        .red_second   (red_second),
        .format_valid (format_valid),
        .format_ready (format_ready),
        .format_data  (format_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Color matrix model
    // ------------------------------------------------------------------
    function automatic logic [7:0] saturate8(input int x);
        if (x < 0)
            return 8'd0;
        else if (x > 255)
            return 8'd255;
        else
            return x[7:0];
    endfunction

    function automatic bgr_t pixel_from_ycbcr(input yuvc_pkg::yuvc_format_t fmt,
                                              input logic [15:0] y,
                                              input logic [15:0] u, input logic [15:0] v);
        int   cy;
        int   du;
        int   dv;
        int   r;
        int   g;
        int   b;
        bgr_t px;
        if (fmt == yuvc_pkg::FMT_NV12)
        begin
            cy = int'(y[7:0]) - 16;
            du = int'(u[7:0]) - 128;
            dv = int'(v[7:0]) - 128;
            r  = (298 * cy + 409 * dv + 128) >>> 8;
            g  = (298 * cy - 100 * du - 208 * dv + 128) >>> 8;
            b  = (298 * cy + 516 * du + 128) >>> 8;
        end
        else
        begin
            // integer divide truncates toward zero, the final shift floors
            cy = (int'(y[15:6]) - 64) * 298;
            du = (int'(u[15:6]) - 512) * 291;
            dv = (int'(v[15:6]) - 512) * 291;
            r  = (cy + (1613 * dv) / 1024) >>> 10;
            g  = (cy - (192 * du) / 1024 - (480 * dv) / 1024) >>> 10;
            b  = (cy + (1900 * du) / 1024) >>> 10;
        end
        px.b = saturate8(b);
        px.g = saturate8(g);
        px.r = saturate8(r);
        return px;
    endfunction

    function automatic bgr_pair_t bgr_from_ycbcr(input yuvc_pkg::yuvc_format_t fmt,
                                                 input ycbcr_pair_t p);
        bgr_pair_t res;
        res.first  = pixel_from_ycbcr(fmt, p.luma_first, p.chroma_blue, p.chroma_red);
        res.second = pixel_from_ycbcr(fmt, p.luma_second, p.chroma_blue, p.chroma_red);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Pair sender, format writer
    // ------------------------------------------------------------------
    task automatic send_pair(input ycbcr_pair_t p);
        int gap;
        if (tx_gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            pair_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair_valid  <= 1'b1;
        luma_first  <= p.luma_first;
        luma_second <= p.luma_second;
        chroma_blue <= p.chroma_blue;
        chroma_red  <= p.chroma_red;
        do
            @(posedge clk);
        while (pair_stall);
        expected_pixels.push_back(bgr_from_ycbcr(format_model, p));
    endtask

    task automatic send_codes(input logic [15:0] y0, input logic [15:0] y1,
                              input logic [15:0] u, input logic [15:0] v);
        ycbcr_pair_t p;
        p.luma_first  = y0;
        p.luma_second = y1;
        p.chroma_blue = u;
        p.chroma_red  = v;
        send_pair(p);
    endtask

    task automatic release_pair();
        pair_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_format(input yuvc_pkg::yuvc_format_t fmt);
        format_valid <= 1'b1;
        format_data  <= fmt;
        do
            @(posedge clk);
        while (!format_ready);
        format_valid <= 1'b0;
        format_model = fmt;
    endtask

    // One random sample code; mostly raw 16-bit, some nominal-range codes
    function automatic logic [15:0] random_code(input bit is_luma);
        int lo;
        int hi;
        unique case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            1, 2, 3:
            begin
                lo = is_luma ? 16 : 16;
                hi = is_luma ? 235 : 240;
                if (format_model == yuvc_pkg::FMT_NV12)
                    return {8'($urandom_range(0, 255)), 8'($urandom_range(lo, hi))};
                return {10'($urandom_range(lo * 4, hi * 4)), 6'($urandom_range(0, 63))};
            end
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic ycbcr_pair_t random_pair();
        ycbcr_pair_t p;
        p.luma_first  = random_code(1'b1);
        p.luma_second = random_code(1'b1);
        p.chroma_blue = random_code(1'b0);
        p.chroma_red  = random_code(1'b0);
        return p;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_pair(random_pair());
    endtask

    // ------------------------------------------------------------------
    // Output side: stall generator, checker, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        int burst;
        burst = 0;
        pixel_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                burst = hold_request;
                hold_request = 0;
            end
            else if (burst == 0 && rx_gaps_on && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 14);
            if (burst > 0)
            begin
                pixel_stall <= 1'b1;
                burst--;
            end
            else
                pixel_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_channel(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        bgr_pair_t want;
        if (rst_n && pixel_valid && !pixel_stall)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("pixel beat with no pair outstanding");
            else
            begin
                want = expected_pixels.pop_front();
                check_channel("blue_first",   blue_first,   want.first.b);
                check_channel("green_first",  green_first,  want.first.g);
                check_channel("red_first",    red_first,    want.first.r);
                check_channel("blue_second",  blue_second,  want.second.b);
                check_channel("green_second", green_second, want.second.g);
                check_channel("red_second",   red_second,   want.second.r);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pair_valid && !pair_stall) || (pixel_valid && !pixel_stall) ||
            (format_valid && format_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= MaxQuietCycles)
        begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("** yuv420_to_bgra_converter: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_nv12_corners();
        write_format(yuvc_pkg::FMT_NV12);
        send_codes(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_codes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_codes(16'd16, 16'd235, 16'd128, 16'd128);       // black and white
        send_codes(16'hA510, 16'h5AEB, 16'hC380, 16'h3F80);  // drop high byte
        send_codes(16'd128, 16'd128, 16'd0, 16'd255);
        send_codes(16'd128, 16'd128, 16'd255, 16'd0);
        send_codes(16'd0, 16'd255, 16'd240, 16'd16);
        send_codes(16'd255, 16'd0, 16'd16, 16'd240);
        send_codes(16'd81, 16'd145, 16'd90, 16'd240);
        release_pair();
        wait_drained();
    endtask

    task automatic test_p010_corners();
        write_format(yuvc_pkg::FMT_P010);
        send_codes(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_codes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_codes(16'd64 << 6, 16'd940 << 6, 16'd512 << 6, 16'd512 << 6);
        // low six bits are padding
        send_codes((16'd64 << 6) | 16'h3F, (16'd940 << 6) | 16'h15, 16'h803F, 16'h802A);
        send_codes(16'd500 << 6, 16'd500 << 6, 16'd511 << 6, 16'd513 << 6);
        send_codes(16'd500 << 6, 16'd501 << 6, 16'd513 << 6, 16'd511 << 6);
        send_codes(16'd512 << 6, 16'd512 << 6, 16'd0, 16'hFFC0);
        send_codes(16'd512 << 6, 16'd512 << 6, 16'hFFC0, 16'd0);
        send_codes(16'd0, 16'hFFC0, 16'd64 << 6, 16'd960 << 6);
        send_codes(16'd1023 << 6, 16'd0, 16'd960 << 6, 16'd64 << 6);
        release_pair();
        wait_drained();
    endtask

    task automatic test_random_formats();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_format(phase[0] ? yuvc_pkg::FMT_NV12 : yuvc_pkg::FMT_P010);
            send_random(250);
            // pause the sender until every pixel beat has come back
            release_pair();
            wait_drained();
        end
    endtask

    task automatic test_output_backpressure();
        write_format(($urandom_range(0, 1) != 0) ? yuvc_pkg::FMT_P010 : yuvc_pkg::FMT_NV12);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        hold_request = 200;
        send_random(60);
        release_pair();
        wait_drained();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    task automatic test_full_rate_stream();
        write_format(($urandom_range(0, 1) != 0) ? yuvc_pkg::FMT_P010 : yuvc_pkg::FMT_NV12);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        send_random(300);
        release_pair();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        pair_valid     = 1'b0;
        luma_first     = '0;
        luma_second    = '0;
        chroma_blue    = '0;
        chroma_red     = '0;
        format_valid   = 1'b0;
        format_data    = 1'b0;
        format_model   = yuvc_pkg::FMT_NV12;
        mismatch_count = 0;
        quiet_cycles   = 0;
        tx_gaps_on     = 1'b0;
        rx_gaps_on     = 1'b0;
        hold_request   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_nv12_corners();
        test_p010_corners();
        test_random_formats();
        test_output_backpressure();
        test_full_rate_stream();

        wait_drained();
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d pixel beats never arrived", expected_pixels.size()));
        if (mismatch_count == 0)
            $display("** yuv420_to_bgra_converter: PASSED **");
        else
            $display("** yuv420_to_bgra_converter: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/yuvc_pkg.sv
rtl/core/yuvc_chroma.sv
rtl/core/yuvc_lane.sv
rtl/core/yuv420_to_bgra_converter.sv
verif/tb_top.sv
